// ----- design/pcx_rle_line_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// PCX RLE line encoder assertion macros
// Concurrent check macros, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_LINE_ENCODER_MACROS_SVH
`define PCX_RLE_LINE_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define PCX_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be true outside reset
`define PCX_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PCX_ASSERT_CLK(lbl, prop, msg)
`define PCX_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/pcxrle_pkg.sv -----
// ----------------------------------------------------------------------------
// PCX RLE package
// Beat types, burst type, constants and the run-to-bytes function.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	localparam logic [7:0] RLE_MARK    = 8'hC0;
	localparam logic [5:0] RLE_MAX_RUN = 6'd63;

	// most bytes one pixel can cause: two flushed runs of two bytes each
	localparam int BURST_MAX = 4;
	localparam int BIDX_W    = $clog2(BURST_MAX);
	localparam int BCNT_W    = $clog2(BURST_MAX + 1);

	// burst queue depth
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0] pixel;
		logic       line_end;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_of_item;
	} code_beat_t;

	// bytes of one flushed run
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [1:0] n;
	} run_bytes_t;

	// all bytes caused by one pixel, in order, bytes[0] first
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [BCNT_W-1:0]         count;
	} burst_t;

	// empty run: nothing; short low run: raw byte; else marker then value
	function automatic run_bytes_t run_emit(input logic [7:0] value, input logic [5:0] cnt);
		run_bytes_t r;
		r.b0 = value;
		r.b1 = value;
		if (cnt == 6'd0) begin
			r.n = 2'd0;
		end else if (cnt == 6'd1 && value[7:6] != 2'b11) begin
			r.n = 2'd1;
		end else begin
			r.b0 = RLE_MARK | {2'b00, cnt};
			r.n  = 2'd2;
		end
		return r;
	endfunction

endpackage

// ----- design/pcxrle_front.sv -----
// ----------------------------------------------------------------------------
// PCX RLE front end
// Holds run state; takes one pixel per cycle unless q_full; builds byte burst.
// ----------------------------------------------------------------------------
module pcxrle_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pcxrle_pkg::pix_beat_t pix,
	input  logic                  q_full,
	output logic                  q_push,
	output pcxrle_pkg::burst_t    q_burst
);
	import pcxrle_pkg::*;

	logic [7:0] run_value_q;
	logic [5:0] run_count_q;
	logic       line_open_q;

	logic [7:0] val_n;
	logic [5:0] cnt_n;
	logic       open_n;
	logic [5:0] cnt_inc;
	logic [7:0] a_val;
	logic [5:0] a_cnt;
	logic [7:0] b_val;
	logic [5:0] b_cnt;
	run_bytes_t a_run;
	run_bytes_t b_run;
	logic       accept;

	assign pix_ready = !q_full;
	assign accept    = pix_valid && pix_ready;
	assign cnt_inc   = run_count_q + 6'd1;

	// classify pixel: first flush (value change or full run), then line end flush
	always_comb begin
		val_n  = run_value_q;
		cnt_n  = run_count_q;
		open_n = line_open_q;
		a_val  = run_value_q;
		a_cnt  = 6'd0;
		b_val  = run_value_q;
		b_cnt  = 6'd0;
		if (!line_open_q) begin
			val_n  = pix.pixel;
			cnt_n  = 6'd1;
			open_n = 1'b1;
		end else if (pix.pixel == run_value_q) begin
			if (cnt_inc == RLE_MAX_RUN) begin
				a_cnt = RLE_MAX_RUN;
				cnt_n = 6'd0;
			end else begin
				cnt_n = cnt_inc;
			end
		end else begin
			a_cnt = run_count_q;
			val_n = pix.pixel;
			cnt_n = 6'd1;
		end
		if (pix.line_end) begin
			b_val  = val_n;
			b_cnt  = cnt_n;
			cnt_n  = 6'd0;
			open_n = 1'b0;
		end
	end

	assign a_run = run_emit(a_val, a_cnt);
	assign b_run = run_emit(b_val, b_cnt);

	// pack both runs back to back
	always_comb begin
		q_burst.bytes = '{default: b_run.b1};
		q_burst.count = BCNT_W'({1'b0, a_run.n} + {1'b0, b_run.n});
		case (a_run.n)
			2'd0: begin
				q_burst.bytes[0] = b_run.b0;
				q_burst.bytes[1] = b_run.b1;
			end
			2'd1: begin
				q_burst.bytes[0] = a_run.b0;
				q_burst.bytes[1] = b_run.b0;
				q_burst.bytes[2] = b_run.b1;
			end
			default: begin
				q_burst.bytes[0] = a_run.b0;
				q_burst.bytes[1] = a_run.b1;
				q_burst.bytes[2] = b_run.b0;
				q_burst.bytes[3] = b_run.b1;
			end
		endcase
	end

	assign q_push = accept && (q_burst.count != '0);

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			run_count_q <= '0;
			line_open_q <= 1'b0;
		end else if (accept) begin
			run_value_q <= val_n;
			run_count_q <= cnt_n;
			line_open_q <= open_n;
		end
	end

endmodule

// ----- design/pcxrle_queue.sv -----
// ----------------------------------------------------------------------------
// PCX RLE burst queue
// Small register queue of byte bursts between front and back ends.
// ----------------------------------------------------------------------------
module pcxrle_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pcxrle_pkg::burst_t push_burst,
	input  logic               pop,
	output pcxrle_pkg::burst_t head,
	output logic               empty,
	output logic               full
);
	import pcxrle_pkg::*;

	burst_t              entry_q [Q_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == QCNT_W'(Q_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_burst;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- design/pcxrle_back.sv -----
// ----------------------------------------------------------------------------
// PCX RLE back end
// Walks the head burst one byte per cycle into the output register when free.
// ----------------------------------------------------------------------------
module pcxrle_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcxrle_pkg::burst_t     head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   code_valid,
	input  logic                   code_ready,
	output pcxrle_pkg::code_beat_t code
);
	import pcxrle_pkg::*;

	logic [BIDX_W-1:0] idx_q;
	logic              out_valid_q;
	code_beat_t        out_q;
	logic              load;
	logic              take;
	logic              at_last;

	assign load    = !out_valid_q || code_ready;
	assign take    = load && !empty;
	assign at_last = (BCNT_W'(idx_q) + BCNT_W'(1)) == head.count;
	assign pop     = take && at_last;

	assign code_valid = out_valid_q;
	assign code       = out_q;

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.code_byte    <= head.bytes[idx_q];
			out_q.last_of_item <= at_last;
		end
	end

	// byte index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !empty;
			end
			if (take) begin
				idx_q <= at_last ? '0 : idx_q + BIDX_W'(1);
			end
		end
	end

endmodule

// ----- design/pcx_rle_line_encoder.sv -----
// ----------------------------------------------------------------------------
// PCX RLE line encoder
// Takes one pixel beat per cycle and emits PCX run-length code beats. A pixel
// beat is taken every cycle while the four-entry burst queue has room; the
// output delivers one code byte per cycle while code_ready is high, so the
// sustained rate is one pixel per cycle as long as pixels cause at most one
// byte on average. A pixel that closes runs may cause up to four bytes, which
// the queue absorbs and the back end drains at one byte per cycle into a
// registered output. last_of_item marks the final byte caused by one pixel.
// ----------------------------------------------------------------------------
`include "pcx_rle_line_encoder_macros.svh"

module pcx_rle_line_encoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  pcxrle_pkg::pix_beat_t  pix,
	output logic                   code_valid,
	input  logic                   code_ready,
	output pcxrle_pkg::code_beat_t code
);
	import pcxrle_pkg::*;

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	burst_t q_in;
	burst_t q_head;

	pcxrle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_burst   (q_in)
	);

	pcxrle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_burst (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	pcxrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	// checks
	`PCX_ASSERT_NEVER(a_no_overflow, q_push && q_full, "burst pushed into full queue")
	`PCX_ASSERT_NEVER(a_no_underflow, q_pop && q_empty, "burst popped from empty queue")
	`PCX_ASSERT_CLK(a_burst_nonempty, q_push |-> (q_in.count != '0), "empty burst queued")

endmodule

// ----- bench/tb_pcx_rle_line_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX RLE line encoder testbench
// Drives pixel beats through a short directed table and then random scan
// lines built from runs of random length. A behavioral encoder predicts the
// code beats of each accepted pixel; typed directed rows give them instead.
// Every code beat is checked, in order, against the oldest prediction. Both
// sides idle at random.
module tb_pcx_rle_line_encoder;
	import pcxrle_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 270;
	localparam int DRAIN_CYCLES = 10;
	localparam int N_DIR        = 19;

	// one row of directed stimulus; b0/b1 hold typed-in bytes when typed is set
	typedef struct packed {
		logic [7:0] px;
		logic       le;
		logic [6:0] reps;
		logic       typed;
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
	} pix_row_t;

	localparam pix_row_t DIR_ROWS [0:N_DIR-1] = '{
		'{8'h00, 1'b1, 7'd1,  1'b1, 2'd1, 8'h00, 8'h00},  // one-pixel line, raw low
		'{8'hFF, 1'b1, 7'd1,  1'b1, 2'd2, 8'hC1, 8'hFF},  // one-pixel line, top bits set
		'{8'hC0, 1'b1, 7'd1,  1'b1, 2'd2, 8'hC1, 8'hC0},  // smallest marked value
		'{8'hBF, 1'b1, 7'd1,  1'b1, 2'd1, 8'hBF, 8'h00},  // largest raw value
		'{8'h3F, 1'b0, 7'd2,  1'b0, 2'd0, 8'h00, 8'h00},  // first pixel emits nothing
		'{8'h55, 1'b0, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},  // value change flushes run
		'{8'hAA, 1'b1, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},  // change plus line end
		'{8'h12, 1'b0, 7'd63, 1'b0, 2'd0, 8'h00, 8'h00},  // run hits the limit
		'{8'h12, 1'b0, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},  // equal pixel counts from 1
		'{8'h34, 1'b1, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h77, 1'b0, 7'd62, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h77, 1'b1, 7'd1,  1'b1, 2'd2, 8'hFF, 8'h77},  // limit on line end, empty run
		'{8'h9A, 1'b0, 7'd63, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h9B, 1'b1, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},  // change after limit flushes none
		'{8'hC5, 1'b0, 7'd2,  1'b0, 2'd0, 8'h00, 8'h00},
		'{8'hC7, 1'b1, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},  // two marked runs, four bytes
		'{8'h01, 1'b0, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h02, 1'b0, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h01, 1'b1, 7'd1,  1'b0, 2'd0, 8'h00, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       pix_valid;
	logic       pix_ready;
	pix_beat_t  pix;
	logic       code_valid;
	logic       code_ready;
	code_beat_t code;

	// encoder state as predicted
	logic [7:0] pred_value;
	logic [5:0] pred_count;
	logic       pred_open;

	code_beat_t expected_codes [$];
	int         errors = 0;
	int         stall_cnt = 0;
	int         sent = 0;
	bit         tx_idle = 1'b1;
	bit         rx_idle = 1'b1;

	pcx_rle_line_encoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// close the current run into the byte list
	function automatic void flush_run(inout logic [3:0][7:0] bytes, inout int n);
		if (pred_count == 6'd0)
			return;
		if (pred_count == 6'd1 && pred_value[7:6] != 2'b11) begin
			bytes[n] = pred_value;
			n = n + 1;
		end else begin
			bytes[n]     = RLE_MARK | {2'b00, pred_count};
			bytes[n + 1] = pred_value;
			n = n + 2;
		end
	endfunction

	// bytes caused by one pixel, in order
	function automatic void pcx_encode(input logic [7:0] px, input logic le,
			output logic [3:0][7:0] bytes, output int n);
		bytes = '0;
		n = 0;
		if (!pred_open) begin
			pred_value = px;
			pred_count = 6'd1;
			pred_open  = 1'b1;
		end else if (px == pred_value) begin
			pred_count = pred_count + 6'd1;
			if (pred_count == RLE_MAX_RUN) begin
				flush_run(bytes, n);
				pred_count = 6'd0;
			end
		end else begin
			flush_run(bytes, n);
			pred_value = px;
			pred_count = 6'd1;
		end
		if (le) begin
			flush_run(bytes, n);
			pred_count = 6'd0;
			pred_open  = 1'b0;
		end
	endfunction

	function automatic void push_codes(input logic [3:0][7:0] bytes, input int n);
		code_beat_t beat;
		for (int i = 0; i < n; i++) begin
			beat.code_byte    = bytes[i];
			beat.last_of_item = (i == n - 1);
			expected_codes.push_back(beat);
		end
	endfunction

	// present one pixel beat and wait for it to be taken
	task automatic send_pixel(input logic [7:0] px, input logic le);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= '{pixel: px, line_end: le};
		do @(posedge clk); while (!pix_ready);
		sent = sent + 1;
	endtask

	// hold the sender off until every predicted beat has come out
	task automatic drain_codes();
		pix_valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
	endtask

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && pix_ready) || (code_valid && code_ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// code side: random backpressure and in-order checking
	initial begin
		int gap;
		code_beat_t exp_beat;
		code_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				code_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			code_ready <= 1'b1;
			do @(posedge clk); while (!code_valid);
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected code beat, actual code_byte %02h last_of_item %0b",
					$time, code.code_byte, code.last_of_item);
				errors++;
			end else begin
				exp_beat = expected_codes.pop_front();
				if (code.code_byte !== exp_beat.code_byte) begin
					$display("%0t: code_byte mismatch, expected %02h, actual %02h",
						$time, exp_beat.code_byte, code.code_byte);
					errors++;
				end
				if (code.last_of_item !== exp_beat.last_of_item) begin
					$display("%0t: last_of_item mismatch, expected %0b, actual %0b",
						$time, exp_beat.last_of_item, code.last_of_item);
					errors++;
				end
			end
			if ($urandom_range(0, 31) == 0)
				rx_idle = !rx_idle;
		end
	end

	// pixel side: reset, directed table, random lines, drain
	initial begin
		logic [3:0][7:0] bytes;
		logic [3:0][7:0] typed_bytes;
		int              n;
		int              line_len;
		int              pos;
		int              run_len;
		int              sel;
		logic [7:0]      val;
		bit              drained;

		arst_n     <= 1'b0;
		pix_valid  <= 1'b0;
		pix        <= '0;
		pred_value = 8'h00;
		pred_count = 6'd0;
		pred_open  = 1'b0;
		drained    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int r = 0; r < N_DIR; r++) begin
			tx_idle = ($urandom_range(0, 2) != 0);
			for (int k = 0; k < DIR_ROWS[r].reps; k++) begin
				send_pixel(DIR_ROWS[r].px, DIR_ROWS[r].le);
				pcx_encode(DIR_ROWS[r].px, DIR_ROWS[r].le, bytes, n);
				if (DIR_ROWS[r].typed) begin
					typed_bytes    = '0;
					typed_bytes[0] = DIR_ROWS[r].b0;
					typed_bytes[1] = DIR_ROWS[r].b1;
					push_codes(typed_bytes, DIR_ROWS[r].n);
				end else begin
					push_codes(bytes, n);
				end
			end
		end
		drain_codes();

		// random scan lines made of runs
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			tx_idle  = ($urandom_range(0, 3) != 0);
			line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
				: $urandom_range(1, 12);
			pos = 0;
			while (pos < line_len) begin
				sel = $urandom_range(0, 5);
				case (sel)
					0:       val = 8'h00;
					1:       val = 8'hFF;
					2:       val = 8'hC0 | 8'($urandom_range(0, 63));
					3:       val = 8'($urandom_range(0, 191));
					default: val = 8'($urandom_range(0, 255));
				endcase
				sel = $urandom_range(0, 9);
				if (sel == 0)
					run_len = $urandom_range(55, 70);
				else if (sel < 4)
					run_len = $urandom_range(2, 5);
				else
					run_len = 1;
				for (int k = 0; k < run_len && pos < line_len; k++) begin
					send_pixel(val, pos == line_len - 1);
					pcx_encode(val, pos == line_len - 1, bytes, n);
					push_codes(bytes, n);
					pos++;
				end
			end
			// one mid-run pause with the pipeline empty
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				drain_codes();
				drained = 1'b1;
			end
		end

		drain_codes();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/pcxrle_pkg.sv
design/pcxrle_front.sv
design/pcxrle_queue.sv
design/pcxrle_back.sv
design/pcx_rle_line_encoder.sv
bench/tb_pcx_rle_line_encoder.sv
